@@ rtl/jssd_pkg.sv @@
`timescale 1ns / 1ps

package jssd_pkg;

  localparam int ID_W        = 4;
  localparam int DUR_W       = 16;
  localparam int TIME_W      = 32;
  localparam int MEM_W       = ID_W + DUR_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 112;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_SCHED = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [ID_W-1:0]  task_id;
    logic [ID_W-1:0]  step_slot;
    logic [ID_W-1:0]  machine_id;
    logic [DUR_W-1:0] step_duration;
    logic             slot_end;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  task_id;
    logic [ID_W-1:0]  step;
    logic             ok;
    logic             last;
    logic [ID_W-1:0]  machine;
    logic [DUR_W-1:0] duration;
  } sched_t;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [ID_W-1:0]   step;
    logic [ID_W-1:0]   machine;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] makespan;
    logic              done;
    status_e           status;
  } res_t;

endpackage

@@ rtl/jssd_step_stage.sv @@
`timescale 1ns / 1ps

module jssd_step_stage import jssd_pkg::*; #(
  parameter int MAX_TASKS    = 16,
  parameter int MAX_MACHINES = 16,
  parameter int MAX_STEPS    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  in_item_t in_i,
  output logic     b_valid_o,
  input  logic     b_ready_i,
  output sched_t   b_item_o
);

  localparam int Depth    = MAX_TASKS * MAX_STEPS;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int TaskIdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int StepW    = $clog2(MAX_STEPS + 1);

  logic                 a_valid_q;
  in_item_t             a_q;
  logic                 b_valid_q;
  sched_t               sched_q;
  logic [MEM_W-1:0]     step_mem [Depth];
  logic [Depth-1:0]     present_q;
  logic [Depth-1:0]     final_q;
  logic [StepW-1:0]     next_step_q [MAX_TASKS];

  logic                 a_load;
  logic                 a_sched;
  logic                 b_free;
  logic                 a_done;
  logic                 task_ok;
  logic                 load_ok;
  logic                 exhausted;
  logic                 present_hit;
  logic                 step_ok;
  logic [TaskIdxW-1:0]  tidx;
  logic [StepW-1:0]     step;
  logic [AddrW-1:0]     base;
  logic [AddrW-1:0]     addr;
  logic [AddrW-1:0]     prev_addr;

  always_comb begin
    a_load      = (a_q.opcode == OP_LOAD);
    a_sched     = (a_q.opcode == OP_SCHED);
    task_ok     = (32'(a_q.task_id) < MAX_TASKS);
    tidx        = TaskIdxW'(a_q.task_id);
    step        = task_ok ? next_step_q[tidx] : '0;
    base        = AddrW'(32'(tidx) * MAX_STEPS);
    load_ok     = task_ok && (32'(a_q.step_slot) < MAX_STEPS)
                  && (32'(a_q.machine_id) < MAX_MACHINES);
    addr        = a_load ? base + AddrW'(a_q.step_slot) : base + AddrW'(step);
    prev_addr   = base + AddrW'(step) - AddrW'(1);
    exhausted   = (step != '0) ? final_q[prev_addr] : 1'b0;
    present_hit = (32'(step) < MAX_STEPS) ? present_q[addr] : 1'b0;
    step_ok     = task_ok && !exhausted && present_hit;
  end

  assign b_free    = !b_valid_q || b_ready_i;
  assign a_done    = a_valid_q && (a_load || b_free);
  assign s_ready_o = !a_valid_q || a_done;
  assign b_valid_o = b_valid_q;
  assign b_item_o  = sched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (s_ready_o) begin
        a_valid_q <= s_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q && a_sched;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      a_q <= in_i;
    end
    if (b_free && a_valid_q && a_sched) begin
      sched_q.task_id <= a_q.task_id;
      sched_q.step    <= ID_W'(step);
      sched_q.ok      <= step_ok;
      sched_q.last    <= a_q.last;
      {sched_q.machine, sched_q.duration} <= step_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_load && load_ok) begin
      step_mem[addr] <= {a_q.machine_id, a_q.step_duration};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      final_q   <= '0;
    end else if (a_valid_q && a_load && load_ok) begin
      present_q[addr] <= 1'b1;
      final_q[addr]   <= a_q.slot_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        next_step_q[i] <= '0;
      end
    end else if (a_valid_q && a_sched && b_free) begin
      if (step_ok) begin
        next_step_q[tidx] <= step + StepW'(1);
      end
      if (a_q.last) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          next_step_q[i] <= '0;
        end
      end
    end
  end

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_load && b_free |=> !b_valid_q)
    else $error("load request reached the timing stage");

  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && task_ok |-> 32'(step) <= MAX_STEPS)
    else $error("task step counter beyond table depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_sched && b_free && a_q.last |=> next_step_q[0] == '0)
    else $error("step counters not cleared at end of sequence");

endmodule

@@ rtl/jssd_time_stage.sv @@
`timescale 1ns / 1ps

module jssd_time_stage import jssd_pkg::*; #(
  parameter int MAX_TASKS    = 16,
  parameter int MAX_MACHINES = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   b_valid_i,
  output logic   b_ready_o,
  input  sched_t b_item_i,
  output logic   m_valid_o,
  input  logic   m_ready_i,
  output res_t   res_o
);

  localparam int TaskIdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int MachIdxW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

  logic [TIME_W-1:0]   ready_q [MAX_TASKS];
  logic [TIME_W-1:0]   free_q [MAX_MACHINES];
  logic [TIME_W-1:0]   mk_q;
  logic                m_valid_q;
  res_t                res_q;

  logic                out_free;
  logic                b_done;
  logic [TaskIdxW-1:0] tidx;
  logic [MachIdxW-1:0] midx;
  logic [TIME_W-1:0]   tr;
  logic [TIME_W-1:0]   mf;
  logic [TIME_W-1:0]   start;
  logic [TIME_W:0]     sum;
  logic                sat;
  logic [TIME_W-1:0]   finish;
  logic [TIME_W-1:0]   mk_d;
  res_t                res_d;

  always_comb begin
    tidx   = TaskIdxW'(b_item_i.task_id);
    midx   = MachIdxW'(b_item_i.machine);
    tr     = ready_q[tidx];
    mf     = free_q[midx];
    start  = (tr > mf) ? tr : mf;
    sum    = {1'b0, start} + (TIME_W + 1)'(b_item_i.duration);
    sat    = sum[TIME_W];
    finish = sat ? '1 : sum[TIME_W-1:0];
    mk_d   = (b_item_i.ok && (finish > mk_q)) ? finish : mk_q;

    res_d.task_id  = b_item_i.task_id;
    res_d.step     = b_item_i.step;
    res_d.makespan = mk_d;
    res_d.done     = b_item_i.last;
    if (b_item_i.ok) begin
      res_d.machine = b_item_i.machine;
      res_d.start   = start;
      res_d.finish  = finish;
      res_d.status  = sat ? ST_SAT : ST_OK;
    end else begin
      res_d.machine = '0;
      res_d.start   = '0;
      res_d.finish  = '0;
      res_d.status  = ST_MISS;
    end
  end

  assign out_free  = !m_valid_q || m_ready_i;
  assign b_ready_o = out_free;
  assign b_done    = b_valid_i && out_free;
  assign m_valid_o = m_valid_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= b_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_done) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        ready_q[i] <= '0;
      end
      for (int i = 0; i < MAX_MACHINES; i++) begin
        free_q[i] <= '0;
      end
      mk_q <= '0;
    end else if (b_done) begin
      if (b_item_i.ok) begin
        ready_q[tidx] <= finish;
        free_q[midx]  <= finish;
        mk_q          <= mk_d;
      end
      if (b_item_i.last) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          ready_q[i] <= '0;
        end
        for (int i = 0; i < MAX_MACHINES; i++) begin
          free_q[i] <= '0;
        end
        mk_q <= '0;
      end
    end
  end

  a_sat_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && res_q.status == ST_SAT |-> res_q.finish == '1)
    else $error("saturated result without full-scale finish time");

  a_mk_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && res_q.status != ST_MISS |-> res_q.makespan >= res_q.finish)
    else $error("makespan below finish time");

  a_mk_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_done && b_item_i.last |=> mk_q == '0)
    else $error("makespan not cleared at end of sequence");

endmodule

@@ rtl/job_shop_sequence_decoder.sv @@
`timescale 1ns / 1ps

// Job-shop schedule decoder. Load requests (tuser 0) write one step of a task
// into the step table and give no result; schedule requests (tuser 1) take the
// named task's next step and return its machine, start, finish and the running
// makespan, with status in tuser and tlast marking the end of the sequence,
// after which task, machine and makespan state clear. One request is taken
// every cycle unless a schedule request waits on a stalled output. The step
// stage registers the step lookup and single-port step table read; the time
// stage registers the max, add and saturate against task and machine times.
// Step table entries need no initialisation: the present bits clear at reset.

module job_shop_sequence_decoder import jssd_pkg::*; #(
  parameter int MAX_TASKS    = 16,
  parameter int MAX_MACHINES = 16,
  parameter int MAX_STEPS    = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // task_id[3:0], step_slot[7:4], machine_id[11:8], step_duration[27:12],
  // slot_end[28], zero[31:29]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode[0]
  input  logic [0:0]             s_axis_tuser_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // out_task[3:0], out_step[7:4], out_machine[11:8], start_time[43:12],
  // finish_time[75:44], makespan[107:76], zero[111:108]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int OutUsedW = 3 * ID_W + 3 * TIME_W;
  localparam int OutPadW  = OUT_TDATA_W - OutUsedW;

  in_item_t in_item;
  logic     b_valid;
  logic     b_ready;
  sched_t   b_item;
  res_t     res;

  always_comb begin
    in_item.opcode        = opcode_e'(s_axis_tuser_i);
    in_item.task_id       = s_axis_tdata_i[3:0];
    in_item.step_slot     = s_axis_tdata_i[7:4];
    in_item.machine_id    = s_axis_tdata_i[11:8];
    in_item.step_duration = s_axis_tdata_i[27:12];
    in_item.slot_end      = s_axis_tdata_i[28];
    in_item.last          = s_axis_tlast_i;
  end

  jssd_step_stage #(
    .MAX_TASKS    (MAX_TASKS),
    .MAX_MACHINES (MAX_MACHINES),
    .MAX_STEPS    (MAX_STEPS)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .in_i      (in_item),
    .b_valid_o (b_valid),
    .b_ready_i (b_ready),
    .b_item_o  (b_item)
  );

  jssd_time_stage #(
    .MAX_TASKS    (MAX_TASKS),
    .MAX_MACHINES (MAX_MACHINES)
  ) u_time (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .b_valid_i (b_valid),
    .b_ready_o (b_ready),
    .b_item_i  (b_item),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .res_o     (res)
  );

  assign m_axis_tdata_o = {{OutPadW{1'b0}}, res.makespan, res.finish, res.start,
                           res.machine, res.step, res.task_id};
  assign m_axis_tuser_o = res.status;
  assign m_axis_tlast_o = res.done;

endmodule
